[sv/nedq_pkg.sv]
// package for the ned to enu quaternion converter
// shared constants, codes and the pipeline control word; no dependencies
`default_nettype none
package nedq_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int LANES = 4;
    localparam longint unsigned NORM_SCALE = 64'd1000000000000;

    typedef enum logic [1:0] {
        PIV_W = 2'd0,
        PIV_A = 2'd1,
        PIV_B = 2'd2,
        PIV_C = 2'd3
    } nedq_pivot_t;

    typedef struct packed {
        logic             valid;
        logic             ident;
        logic [LANES-1:0] neg;
    } nedq_ctrl_t;

endpackage
`default_nettype wire

[sv/nedq_in_if.sv]
// input channel: one ned quaternion word with valid/ready
// standalone interface, width set by the instantiator
`default_nettype none
interface nedq_in_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ned_w;
    logic signed [W-1:0] ned_x;
    logic signed [W-1:0] ned_y;
    logic signed [W-1:0] ned_z;

    modport source (output valid, ned_w, ned_x, ned_y, ned_z, input ready);
    modport sink (input valid, ned_w, ned_x, ned_y, ned_z, output ready);
endinterface
`default_nettype wire

[sv/nedq_out_if.sv]
// output channel: one enu quaternion word with valid/ready
// standalone interface, width set by the instantiator
`default_nettype none
interface nedq_out_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] enu_w;
    logic signed [W-1:0] enu_x;
    logic signed [W-1:0] enu_y;
    logic signed [W-1:0] enu_z;
    logic                used_identity;

    modport source (output valid, enu_w, enu_x, enu_y, enu_z, used_identity, input ready);
    modport sink (input valid, enu_w, enu_x, enu_y, enu_z, used_identity, output ready);
endinterface
`default_nettype wire

[sv/ned_to_enu_quaternion.sv]
// top level: ned to enu attitude quaternion converter
// uses nedq_pkg, nedq_in_if, nedq_out_if, nedq_prep, nedq_root_stage
`default_nettype none
// Converts a NED attitude quaternion (signed Q1.(W-2)) into the unit ENU quaternion
// (w, y, x, -z), renormalized and sign-fixed by the largest-diagonal rule, with
// used_identity set and the identity emitted when the input norm is at or below 1e-6.
// Fully pipelined: one word per cycle unless the output stalls (two front-end stages,
// one stage per result bit of the shift-and-add normalizer, one output register).
// The whole pipeline holds while the output word is not taken.
module ned_to_enu_quaternion
    import nedq_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    nedq_in_if.sink   in_ch,
    nedq_out_if.source out_ch
);
    localparam int W = COMPONENT_WIDTH;
    localparam int F = W - 2;
    localparam int L = 4 * W + 2;
    localparam int NS = F + 1;

    logic          en;
    nedq_ctrl_t    ctrl_s [NS+1];
    logic [2*W:0]  n2_s [NS+1];
    logic [L-1:0]  rhs_s [NS+1][LANES];
    logic [F:0]    r_s [NS+1][LANES];
    logic [L-1:0]  q_s [NS+1][LANES];
    logic [L-1:0]  p_s [NS+1][LANES];

    logic                out_valid_reg;
    logic signed [W-1:0] comp_reg [LANES];
    logic                ident_reg;
    logic signed [W-1:0] comp_next [LANES];

    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    nedq_prep #(.W(W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid),
        .ned_w    (in_ch.ned_w),
        .ned_x    (in_ch.ned_x),
        .ned_y    (in_ch.ned_y),
        .ned_z    (in_ch.ned_z),
        .ctrl     (ctrl_s[0]),
        .n2       (n2_s[0]),
        .rhs      (rhs_s[0])
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            r_s[0][i] = '0;
            q_s[0][i] = '0;
            p_s[0][i] = '0;
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_root
        nedq_root_stage #(.W(W), .K(F - s)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_s[s]),
            .n2_in    (n2_s[s]),
            .rhs_in   (rhs_s[s]),
            .r_in     (r_s[s]),
            .q_in     (q_s[s]),
            .p_in     (p_s[s]),
            .ctrl_out (ctrl_s[s+1]),
            .n2_out   (n2_s[s+1]),
            .rhs_out  (rhs_s[s+1]),
            .r_out    (r_s[s+1]),
            .q_out    (q_s[s+1]),
            .p_out    (p_s[s+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (ctrl_s[NS].ident)
                comp_next[i] = (i == 0) ? W'(1) << F : '0;
            else if (ctrl_s[NS].neg[i])
                comp_next[i] = -W'(r_s[NS][i]);
            else
                comp_next[i] = W'(r_s[NS][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctrl_s[NS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ident_reg <= ctrl_s[NS].ident;
            for (int i = 0; i < LANES; i++)
                comp_reg[i] <= comp_next[i];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.enu_w         = comp_reg[0];
    assign out_ch.enu_x         = comp_reg[1];
    assign out_ch.enu_y         = comp_reg[2];
    assign out_ch.enu_z         = comp_reg[3];
    assign out_ch.used_identity = ident_reg;

`ifndef ASSERT_OFF
    a_ident_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.used_identity |->
            out_ch.enu_w == (W'(1) << F) && out_ch.enu_x == '0
            && out_ch.enu_y == '0 && out_ch.enu_z == '0)
        else $error("identity word malformed");
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_s[NS].valid |-> r_s[NS][0] <= ((F+1)'(1) << F))
        else $error("normalized magnitude above one");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && ctrl_s[NS].valid |=> out_ch.valid)
        else $error("last stage word not delivered");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctrl_s[NS].valid) && $stable(r_s[NS][0]))
        else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire

[sv/nedq_prep.sv]
// front end: magnitudes and squares, then norm, fallback test, pivot and signs
// two register stages; uses nedq_pkg
`default_nettype none
module nedq_prep
    import nedq_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] ned_w,
    input  wire logic signed [W-1:0] ned_x,
    input  wire logic signed [W-1:0] ned_y,
    input  wire logic signed [W-1:0] ned_z,
    output nedq_ctrl_t               ctrl,
    output logic [2*W:0]             n2,
    output logic [4*W+1:0]           rhs [LANES]
);
    localparam int F   = W - 2;
    localparam int SQW = 2 * W;
    localparam int N2W = 2 * W + 1;
    localparam int L   = 4 * W + 2;
    localparam longint unsigned NORM_LIMIT = (64'd1 << (2 * F)) / NORM_SCALE;

    logic               a_valid_reg;
    logic [LANES-1:0]   a_neg_reg;
    logic [SQW-1:0]     a_sq_reg [LANES];
    logic [LANES-1:0]   a_neg_next;
    logic [SQW-1:0]     a_sq_next [LANES];
    logic [W-1:0]       mag [LANES];
    logic signed [W-1:0] raw [LANES];

    nedq_ctrl_t         b_ctrl_reg;
    nedq_ctrl_t         b_ctrl_next;
    logic [N2W-1:0]     b_n2_reg;
    logic [N2W-1:0]     b_n2_next;
    logic [L-1:0]       b_rhs_reg [LANES];
    logic [N2W-1:0]     s3;
    logic [N2W:0]       three_sw;
    nedq_pivot_t        pivot;
    logic               flip;

    // lane order w, y, x, z
    assign raw[0] = ned_w;
    assign raw[1] = ned_y;
    assign raw[2] = ned_x;
    assign raw[3] = ned_z;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag[i] = raw[i][W-1] ? W'(-raw[i]) : W'(raw[i]);
            a_sq_next[i] = SQW'(mag[i]) * SQW'(mag[i]);
        end
        a_neg_next = {~ned_z[W-1], ned_x[W-1], ned_y[W-1], ned_w[W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_reg <= a_neg_next;
            for (int i = 0; i < LANES; i++)
                a_sq_reg[i] <= a_sq_next[i];
        end
    end

    always_comb
    begin
        s3 = N2W'(a_sq_reg[1]) + N2W'(a_sq_reg[2]) + N2W'(a_sq_reg[3]);
        b_n2_next = s3 + N2W'(a_sq_reg[0]);
        three_sw = (N2W+1)'(a_sq_reg[0]) + ((N2W+1)'(a_sq_reg[0]) << 1);
        if (three_sw > (N2W+1)'(s3))
            pivot = PIV_W;
        else if (a_sq_reg[1] > a_sq_reg[2] && a_sq_reg[1] > a_sq_reg[3])
            pivot = PIV_A;
        else if (a_sq_reg[2] > a_sq_reg[3])
            pivot = PIV_B;
        else
            pivot = PIV_C;
        unique case (pivot)
            PIV_W:   flip = a_neg_reg[0];
            PIV_A:   flip = a_neg_reg[1];
            PIV_B:   flip = a_neg_reg[2];
            PIV_C:   flip = a_neg_reg[3];
            default: flip = 1'b0;
        endcase
        b_ctrl_next.valid = a_valid_reg;
        b_ctrl_next.ident = !(b_n2_next > N2W'(NORM_LIMIT));
        b_ctrl_next.neg   = a_neg_reg ^ {LANES{flip}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctrl_reg <= '0;
        else if (en)
            b_ctrl_reg <= b_ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_n2_reg <= b_n2_next;
            for (int i = 0; i < LANES; i++)
                b_rhs_reg[i] <= L'(a_sq_reg[i]) << (2 * W - 2);
        end
    end

    assign ctrl = b_ctrl_reg;
    assign n2   = b_n2_reg;
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            rhs[i] = b_rhs_reg[i];
    end
endmodule
`default_nettype wire

[sv/nedq_root_stage.sv]
// one result bit of m * 2^f / sqrt(n2) for all four lanes, by shift and add
// one register stage; uses nedq_pkg
`default_nettype none
module nedq_root_stage
    import nedq_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF,
    parameter int K = 0
)(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  nedq_ctrl_t          ctrl_in,
    input  wire logic [2*W:0]   n2_in,
    input  wire logic [4*W+1:0] rhs_in [LANES],
    input  wire logic [W-2:0]   r_in [LANES],
    input  wire logic [4*W+1:0] q_in [LANES],
    input  wire logic [4*W+1:0] p_in [LANES],
    output nedq_ctrl_t          ctrl_out,
    output logic [2*W:0]        n2_out,
    output logic [4*W+1:0]      rhs_out [LANES],
    output logic [W-2:0]        r_out [LANES],
    output logic [4*W+1:0]      q_out [LANES],
    output logic [4*W+1:0]      p_out [LANES]
);
    localparam int F = W - 2;
    localparam int L = 4 * W + 2;

    nedq_ctrl_t    ctrl_reg;
    logic [2*W:0]  n2_reg;
    logic [L-1:0]  rhs_reg [LANES];
    logic [F:0]    r_reg [LANES];
    logic [L-1:0]  q_reg [LANES];
    logic [L-1:0]  p_reg [LANES];
    logic [F:0]    r_next [LANES];
    logic [L-1:0]  q_next [LANES];
    logic [L-1:0]  p_next [LANES];
    logic [L-1:0]  q_try [LANES];
    logic [L-1:0]  p_try [LANES];
    logic          take [LANES];

    // r^2*n2 and r*n2 are carried so each trial bit is a shift and add
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            q_try[i] = q_in[i] + (p_in[i] << (K + 1)) + (L'(n2_in) << (2 * K));
            p_try[i] = p_in[i] + (L'(n2_in) << K);
            take[i]  = !r_in[i][F]
                && ((q_try[i] << 2) + L'(n2_in) <= rhs_in[i] + (p_try[i] << 2));
            r_next[i] = take[i] ? (r_in[i] | ((F+1)'(1) << K)) : r_in[i];
            q_next[i] = take[i] ? q_try[i] : q_in[i];
            p_next[i] = take[i] ? p_try[i] : p_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg <= n2_in;
            for (int i = 0; i < LANES; i++)
            begin
                rhs_reg[i] <= rhs_in[i];
                r_reg[i]   <= r_next[i];
                q_reg[i]   <= q_next[i];
                p_reg[i]   <= p_next[i];
            end
        end
    end

    assign ctrl_out = ctrl_reg;
    assign n2_out   = n2_reg;
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rhs_out[i] = rhs_reg[i];
            r_out[i]   = r_reg[i];
            q_out[i]   = q_reg[i];
            p_out[i]   = p_reg[i];
        end
    end
endmodule
`default_nettype wire
